>>> design/lgr_pkg.sv
// Shared types and constants for the Life generation row engine.
package lgr_pkg;

  localparam int ROW_BITS      = 64;
  localparam int ROW_NUMBER_W  = 10;
  localparam int ROW_COUNT_W   = 11;
  localparam int COLUMN_COUNT_W = 7;
  localparam int ROW_NUMBER_LIMIT = 1024;
  localparam int OUT_TDATA_W   = 80;
  localparam int NBR_COUNT_W   = 4;

  localparam logic [NBR_COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

  // Register indexes; the byte address is the index times four
  localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  typedef struct packed {
    logic [ROW_BITS-1:0]     next_row;
    logic [ROW_NUMBER_W-1:0] row_number;
    logic                    last_row;
    logic                    all_dead;
  } lgr_result_t;

  typedef struct packed {
    logic        valid;
    lgr_result_t data;
  } lgr_push_t;

endpackage

>>> design/lgr_lane.sv
// One cell: counts its eight neighbors and applies the B3/S23 rule.
module lgr_lane (
  input  logic [7:0] nbr,
  input  logic       alive,
  output logic       next_alive
);
  import lgr_pkg::*;

  logic [NBR_COUNT_W-1:0] count;

  always_comb begin
    count = '0;
    for (int k = 0; k < 8; k++) begin
      count = count + NBR_COUNT_W'(nbr[k]);
    end
  end

  assign next_alive = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));

endmodule

>>> design/lgr_row.sv
// Row of cell lanes side by side; merges lane outputs into a masked row and an any-alive flag.
module lgr_row #(
  parameter int LANES = 64
) (
  input  logic [LANES-1:0] above,
  input  logic [LANES-1:0] mid,
  input  logic [LANES-1:0] below,
  input  logic [LANES-1:0] mask,
  output logic [LANES-1:0] next_row,
  output logic             any_set
);
  import lgr_pkg::*;

  // Pad with a dead column on each side; lane k sees padded bits k..k+2.
  logic [LANES+1:0] above_p;
  logic [LANES+1:0] mid_p;
  logic [LANES+1:0] below_p;
  logic [LANES-1:0] lane_out;

  assign above_p = {1'b0, above, 1'b0};
  assign mid_p   = {1'b0, mid, 1'b0};
  assign below_p = {1'b0, below, 1'b0};

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    lgr_lane u_lane (
      .nbr        ({above_p[k+2:k], mid_p[k+2], mid_p[k], below_p[k+2:k]}),
      .alive      (mid[k]),
      .next_alive (lane_out[k])
    );
  end

  assign next_row = lane_out & mask;
  assign any_set  = |next_row;

endmodule

>>> design/lgr_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module lgr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  lgr_pkg::lgr_push_t push_a,
  input  lgr_pkg::lgr_push_t push_b,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output lgr_pkg::lgr_result_t out_data
);
  import lgr_pkg::*;

  lgr_result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]  count_r, count_nxt;
  logic [FIFO_PTR_W-1:0]  wr_b_ptr;
  logic [FIFO_CNT_W-1:0]  push_n;
  logic                   pop;

  assign pop      = out_valid && out_ready;
  assign push_n   = FIFO_CNT_W'(push_a.valid) + FIFO_CNT_W'(push_b.valid);
  assign wr_b_ptr = wr_ptr_r + FIFO_PTR_W'(push_a.valid);

  assign wr_ptr_nxt = wr_ptr_r + push_n[FIFO_PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + push_n - FIFO_CNT_W'(pop);

  // Room for the worst case of two results from the next row.
  assign space_ok  = count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a.valid) begin
      mem_r[wr_ptr_r] <= push_a.data;
    end
    if (push_b.valid) begin
      mem_r[wr_b_ptr] <= push_b.data;
    end
  end

endmodule

>>> design/life_generation_row_engine_top.sv
// Life generation row engine: one B3/S23 generation computed row by row.
// Results enter the queue at their row transfer and are offered in order on out_tvalid.
// Throughput: one row per cycle; the first row of a generation yields no result and the
// final row two (a one-row generation: one), so with out_tready high the queue holds at
// most two and the input never stalls; in_tready drops only while three or more wait.
// Reset (synchronous, rst_n low): stored rows, row counter and queue clear;
// row_count and column_count return to 64.
module life_generation_row_engine_top #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields, low bit up: row_cells[63:0]
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata fields, low bit up: next_row[63:0], row_number[73:64], zero fill [79:74]
  output logic [lgr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser fields, low bit up: all_dead[0]
  output logic [0:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lgr_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < ROW_NUMBER_LIMIT) ? MAX_ROWS : ROW_NUMBER_LIMIT;

  logic [ROW_COUNT_W-1:0]    row_count_r;
  logic [COLUMN_COUNT_W-1:0] column_count_r;
  logic [MAX_COLUMNS-1:0]    older_row_r, older_row_nxt;
  logic [MAX_COLUMNS-1:0]    newer_row_r, newer_row_nxt;
  logic [ROW_NUMBER_W-1:0]   rows_seen_r, rows_seen_nxt;
  logic                      any_alive_r, any_alive_nxt;

  logic                   cfg_write;
  logic                   in_xfer;
  logic                   seen_nz;
  logic                   is_final;
  logic [ROW_COUNT_W-1:0] rows_eff;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [MAX_COLUMNS-1:0] cur_m;
  logic [MAX_COLUMNS-1:0] older_m;
  logic [MAX_COLUMNS-1:0] newer_m;
  logic [MAX_COLUMNS-1:0] above_b;
  logic [MAX_COLUMNS-1:0] row_a;
  logic [MAX_COLUMNS-1:0] row_b;
  logic                   any_a;
  logic                   any_b;
  logic                   space_ok;
  lgr_push_t              push_a;
  lgr_push_t              push_b;
  lgr_result_t            head;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ROW_COUNT:    cfg_prdata = 32'(row_count_r);
      REG_COLUMN_COUNT: cfg_prdata = 32'(column_count_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_W'(64);
      column_count_r <= COLUMN_COUNT_W'(64);
    end else if (cfg_write) begin
      unique case (cfg_paddr[2])
        REG_ROW_COUNT:    row_count_r    <= cfg_pwdata[ROW_COUNT_W-1:0];
        REG_COLUMN_COUNT: column_count_r <= cfg_pwdata[COLUMN_COUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Column mask: a lane is in use when its index is below the column count.
  for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_mask
    assign col_mask[k] = column_count_r > COLUMN_COUNT_W'(k);
  end

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = ROW_COUNT_W'(1);
    end else if (row_count_r > ROW_COUNT_W'(ROW_LIMIT)) begin
      rows_eff = ROW_COUNT_W'(ROW_LIMIT);
    end else begin
      rows_eff = row_count_r;
    end
  end

  assign in_tready = space_ok;
  assign in_xfer   = in_tvalid && in_tready;
  assign seen_nz   = rows_seen_r != '0;
  assign is_final  = ({1'b0, rows_seen_r} + ROW_COUNT_W'(1)) >= rows_eff;

  assign cur_m   = in_tdata[MAX_COLUMNS-1:0] & col_mask;
  assign older_m = older_row_r & col_mask;
  assign newer_m = newer_row_r & col_mask;
  assign above_b = seen_nz ? newer_m : '0;

  // Row above the incoming one
  lgr_row #(.LANES(MAX_COLUMNS)) u_row_mid (
    .above    (older_m),
    .mid      (newer_m),
    .below    (cur_m),
    .mask     (col_mask),
    .next_row (row_a),
    .any_set  (any_a)
  );

  // Incoming row as the final row, dead below
  lgr_row #(.LANES(MAX_COLUMNS)) u_row_last (
    .above    (above_b),
    .mid      (cur_m),
    .below    ('0),
    .mask     (col_mask),
    .next_row (row_b),
    .any_set  (any_b)
  );

  always_comb begin
    push_a.valid           = in_xfer && seen_nz;
    push_a.data.next_row   = ROW_BITS'(row_a);
    push_a.data.row_number = rows_seen_r - ROW_NUMBER_W'(1);
    push_a.data.last_row   = 1'b0;
    push_a.data.all_dead   = 1'b0;

    push_b.valid           = in_xfer && is_final;
    push_b.data.next_row   = ROW_BITS'(row_b);
    push_b.data.row_number = rows_seen_r;
    push_b.data.last_row   = 1'b1;
    push_b.data.all_dead   = !(any_alive_r || (seen_nz && any_a) || any_b);
  end

  always_comb begin
    older_row_nxt = older_row_r;
    newer_row_nxt = newer_row_r;
    rows_seen_nxt = rows_seen_r;
    any_alive_nxt = any_alive_r;
    if (in_xfer) begin
      if (is_final) begin
        // Start a fresh generation
        older_row_nxt = '0;
        newer_row_nxt = '0;
        rows_seen_nxt = '0;
        any_alive_nxt = 1'b0;
      end else begin
        older_row_nxt = newer_row_r;
        newer_row_nxt = cur_m;
        rows_seen_nxt = rows_seen_r + ROW_NUMBER_W'(1);
        any_alive_nxt = any_alive_r || (seen_nz && any_a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_row_r <= '0;
      newer_row_r <= '0;
      rows_seen_r <= '0;
      any_alive_r <= 1'b0;
    end else begin
      older_row_r <= older_row_nxt;
      newer_row_r <= newer_row_nxt;
      rows_seen_r <= rows_seen_nxt;
      any_alive_r <= any_alive_nxt;
    end
  end

  lgr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tdata = OUT_TDATA_W'({head.row_number, head.next_row});
  assign out_tlast = head.last_row;
  assign out_tuser = head.all_dead;

endmodule

>>> design/lgr_checker.sv
// Port-level checks for the Life generation row engine, bound to the top level.
module lgr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic [63:0] in_tdata,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [79:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // out_tvalid, once raised, holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  // The dead-generation flag only comes with the final row.
  a_dead_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("all_dead set on a row that is not last");

  // A dead generation has an empty final row.
  a_dead_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser[0] |-> out_tdata[63:0] == 64'd0)
    else $error("all_dead set with live cells in final row");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind life_generation_row_engine_top lgr_checker u_lgr_checker (.*);

>>> tb/tb_life_generation_row_engine_top.sv
// Self-checking bench for the Life row engine: random row streams, APB setup, result scoreboard.
module tb_life_generation_row_engine_top;
  import lgr_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int ITEM_TARGET      = 1350;
  localparam int QUIET_TAIL       = 100;
  localparam int SETTLE_CYCLES    = 4;

  typedef enum int {
    FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_EMPTY, FILL_FULL, FILL_SPECKS
  } fill_style_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [63:0]            in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [2:0]             cfg_paddr = '0;
  logic [31:0]            cfg_pwdata = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  life_generation_row_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the block state and registers
  logic [63:0]             gen_older = '0;
  logic [63:0]             gen_newer = '0;
  logic [ROW_NUMBER_W-1:0] gen_rows_seen = '0;
  bit                      gen_alive = 1'b0;
  logic [10:0]             cfg_rows_q = 11'd64;
  logic [6:0]              cfg_cols_q = 7'd64;

  lgr_result_t  expected_rows[$];
  logic [63:0]  pending_rows[$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  bit           idle_enable = 1'b1;
  logic         in_xfer = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;

  function automatic logic [63:0] active_mask(input logic [6:0] cols);
    int n;
    n = (cols > 7'd64) ? 64 : int'(cols);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int effective_rows(input logic [10:0] rows);
    int n;
    n = int'(rows);
    if (n > ROW_NUMBER_LIMIT) n = ROW_NUMBER_LIMIT;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic logic [63:0] life_next_row(input logic [63:0] above, input logic [63:0] mid,
                                                input logic [63:0] below, input logic [63:0] mask);
    logic [63:0] nb [8];
    logic [63:0] res;
    int cnt;
    nb[0] = above << 1;
    nb[1] = above;
    nb[2] = above >> 1;
    nb[3] = mid << 1;
    nb[4] = mid >> 1;
    nb[5] = below << 1;
    nb[6] = below;
    nb[7] = below >> 1;
    res = '0;
    for (int lane = 0; lane < 64; lane++) begin
      cnt = 0;
      for (int k = 0; k < 8; k++) cnt += int'(nb[k][lane]);
      if (cnt == int'(BIRTH_COUNT) || (mid[lane] && cnt == int'(SURVIVE_COUNT))) res[lane] = 1'b1;
    end
    return res & mask;
  endfunction

  task automatic predict_row_results(input logic [63:0] cells);
    logic [63:0] mask, cur, nr;
    int seen, rows;
    lgr_result_t r;
    mask = active_mask(cfg_cols_q);
    cur  = cells & mask;
    seen = int'(gen_rows_seen);
    rows = effective_rows(cfg_rows_q);
    if (seen >= 1) begin
      nr = life_next_row(gen_older & mask, gen_newer & mask, cur, mask);
      if (nr != '0) gen_alive = 1'b1;
      r.next_row   = nr;
      r.row_number = ROW_NUMBER_W'(seen - 1);
      r.last_row   = 1'b0;
      r.all_dead   = 1'b0;
      expected_rows.push_back(r);
    end
    if (seen + 1 >= rows) begin
      nr = life_next_row((seen >= 1) ? (gen_newer & mask) : 64'd0, cur, 64'd0, mask);
      r.next_row   = nr;
      r.row_number = ROW_NUMBER_W'(seen);
      r.last_row   = 1'b1;
      r.all_dead   = !(gen_alive || nr != '0);
      expected_rows.push_back(r);
      gen_older     = '0;
      gen_newer     = '0;
      gen_rows_seen = '0;
      gen_alive     = 1'b0;
    end else begin
      gen_older     = gen_newer;
      gen_newer     = cur;
      gen_rows_seen = ROW_NUMBER_W'(seen + 1);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Check results first: a result always belongs to a transfer at an earlier edge
  always @(posedge clk) begin : scoreboard
    lgr_result_t got, want;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got.next_row   = out_tdata[63:0];
        got.row_number = out_tdata[73:64];
        got.last_row   = out_tlast;
        got.all_dead   = out_tuser[0];
        if (expected_rows.size() == 0) begin
          report_mismatch("result with nothing expected", got.next_row, '0);
        end else begin
          want = expected_rows.pop_front();
          if (got.next_row !== want.next_row)
            report_mismatch("next_row", got.next_row, want.next_row);
          if (got.row_number !== want.row_number)
            report_mismatch("row_number", 64'(got.row_number), 64'(want.row_number));
          if (got.last_row !== want.last_row)
            report_mismatch("last_row", 64'(got.last_row), 64'(want.last_row));
          if (got.all_dead !== want.all_dead)
            report_mismatch("all_dead", 64'(got.all_dead), 64'(want.all_dead));
        end
      end
      if (in_tvalid && in_tready) predict_row_results(in_tdata);
    end
  end

  // Row driver: advance on a transfer, otherwise hold
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 6);
        in_tvalid <= 1'b0;
      end else if (pending_rows.size() != 0) begin
        in_tdata  <= pending_rows.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic wait_block_idle();
    while (pending_rows.size() != 0 || in_tvalid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register, then read it back
  task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
    logic [31:0] want;
    wait_block_idle();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_ROW_COUNT) begin
      cfg_rows_q = value[10:0];
      want = {21'd0, value[10:0]};
    end else begin
      cfg_cols_q = value[6:0];
      want = {25'd0, value[6:0]};
    end
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) report_mismatch("register readback", 64'(cfg_prdata), 64'(want));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [63:0] random_row(input fill_style_t style);
    case (style)
      FILL_RANDOM: return {$urandom, $urandom};
      FILL_SPARSE: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      FILL_DENSE:  return {$urandom, $urandom} | {$urandom, $urandom};
      FILL_EMPTY:  return '0;
      FILL_FULL:   return '1;
      default:     return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  task automatic queue_row(input logic [63:0] cells);
    pending_rows.push_back(cells);
    items_sent++;
  endtask

  initial begin : stimulus
    int rows_eff, n, pick;
    bit quiet;
    fill_style_t style;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // One generation at the reset configuration
    for (int i = 0; i < 64; i++) queue_row(random_row(FILL_RANDOM));

    // Directed: edges, known patterns, single-row and masking corners
    write_register(REG_ROW_COUNT, 32'd3);
    write_register(REG_COLUMN_COUNT, 32'd64);
    queue_row('1);
    queue_row('0);
    queue_row(64'h8000_0000_0000_0001);
    queue_row(64'h2);
    queue_row(64'h7);
    queue_row(64'h5);
    queue_row('0);
    queue_row('0);
    queue_row('0);
    write_register(REG_ROW_COUNT, 32'd1);
    queue_row('1);
    queue_row('0);
    write_register(REG_ROW_COUNT, 32'd0);
    queue_row(64'hE);
    write_register(REG_ROW_COUNT, 32'd2);
    write_register(REG_COLUMN_COUNT, 32'd1);
    queue_row('1);
    queue_row('1);
    write_register(REG_COLUMN_COUNT, 32'd0);
    queue_row('1);
    queue_row('1);
    // Oversized counts, then lower the row count mid generation
    write_register(REG_ROW_COUNT, 32'h7FF);
    write_register(REG_COLUMN_COUNT, 32'h7F);
    for (int i = 0; i < 3; i++) queue_row(random_row(FILL_DENSE));
    write_register(REG_ROW_COUNT, 32'd2);
    queue_row(random_row(FILL_DENSE));
    // Narrow the columns mid generation
    write_register(REG_ROW_COUNT, 32'd4);
    write_register(REG_COLUMN_COUNT, 32'd64);
    queue_row('1);
    queue_row('1);
    write_register(REG_COLUMN_COUNT, 32'd8);
    queue_row('1);
    queue_row('1);

    // One full-height generation, row numbers run to the top
    write_register(REG_ROW_COUNT, 32'd1024);
    write_register(REG_COLUMN_COUNT, 32'($urandom_range(2, 64)));
    for (int i = 0; i < ROW_NUMBER_LIMIT; i++)
      queue_row(random_row(fill_style_t'($urandom_range(0, 5))));

    while (items_sent < ITEM_TARGET) begin
      wait_block_idle();
      idle_enable = (items_sent < ITEM_TARGET - QUIET_TAIL)
                    && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0)      n = $urandom_range(0, 1);
      else if (pick == 1) n = $urandom_range(9, 40);
      else                n = $urandom_range(2, 8);
      write_register(REG_ROW_COUNT, 32'(n));
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      n = $urandom_range(0, 1);
        else if (pick == 1) n = $urandom_range(65, 127);
        else if (pick == 2) n = 64;
        else                n = $urandom_range(2, 63);
        write_register(REG_COLUMN_COUNT, 32'(n));
      end
      rows_eff = effective_rows(cfg_rows_q);
      n = rows_eff * $urandom_range(1, 3);
      // Leave a generation open now and then; the next phase finishes it
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, rows_eff);
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
        if (quiet) style = fill_style_t'($urandom_range(int'(FILL_EMPTY), int'(FILL_SPECKS)));
        else       style = fill_style_t'($urandom_range(0, 5));
        if (quiet && style == FILL_FULL) style = FILL_SPARSE;
        queue_row(random_row(style));
      end
    end

    wait_block_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
design/lgr_pkg.sv
design/lgr_lane.sv
design/lgr_row.sv
design/lgr_fifo.sv
design/life_generation_row_engine_top.sv
design/lgr_checker.sv
tb/tb_life_generation_row_engine_top.sv
